@@ hw/rtl/xtlc_pkg.sv @@
// Package for the xor trie less-than counter.
// Holds sizes, codes and the word, token and entry types shared by the cell
// row and the top level. No dependencies.
`timescale 1ns / 1ps

package xtlc_pkg;

    localparam int KEY_BITS   = 31;
    localparam int POOL_NODES = 65536;
    localparam int NODE_W     = $clog2(POOL_NODES);
    localparam int FILL_W     = NODE_W + 1;
    localparam int CNT_W      = 16;
    localparam int NCELLS     = KEY_BITS + 1;
    localparam int LVL_W      = $clog2(KEY_BITS + 1);
    localparam int KPOS_W     = $clog2(KEY_BITS);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POOL_FULL = 2'd1;
    localparam logic [1:0] ST_ABSENT    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Walk modes broadcast to the cells
    localparam logic [2:0] MODE_CHK_INS = 3'd0;
    localparam logic [2:0] MODE_CHK_REM = 3'd1;
    localparam logic [2:0] MODE_QUERY   = 3'd2;
    localparam logic [2:0] MODE_UPD_INS = 3'd3;
    localparam logic [2:0] MODE_UPD_REM = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] key;
        logic [30:0] limit;
    } in_word_t;

    typedef struct packed {
        logic [15:0] count;
        logic [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [2:0]          mode;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] limit;
    } ctrl_t;

    // Token handed from one level cell to the next
    typedef struct packed {
        logic              valid;
        logic              present;
        logic [NODE_W-1:0] node;
        logic              cred_v;
        logic [NODE_W-1:0] cred_node;
        logic [CNT_W-1:0]  total;
        logic [LVL_W-1:0]  missing;
        logic              bad;
    } tok_t;

    // One trie node: child links into the next level and the key count
    typedef struct packed {
        logic              lv;
        logic [NODE_W-1:0] li;
        logic              rv;
        logic [NODE_W-1:0] ri;
        logic [CNT_W-1:0]  cnt;
    } ent_t;

endpackage

@@ hw/rtl/xtlc_cell.sv @@
// One trie level: node memory for that depth, fill count and walk logic.
// Depends on xtlc_pkg. Instantiated once per level by the top level.
`timescale 1ns / 1ps

module xtlc_cell import xtlc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [LVL_W-1:0]  level,
    input  ctrl_t             ctrl,
    input  tok_t              tok_in,
    input  logic [FILL_W-1:0] nxt_fill,
    output logic [FILL_W-1:0] fill_out,
    output tok_t              tok_out
);

    ent_t mem [POOL_NODES];

    tok_t              tok_a_reg;
    logic              fresh_reg;
    ent_t              rd_a_reg;
    ent_t              rd_c_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    tok_t              tok_out_reg;
    tok_t              tok_out_next;
    ent_t              ent;
    ent_t              wdata;
    logic              we;
    logic              leaf;
    logic [KPOS_W-1:0] pos;
    logic              kb;
    logic              lb;
    logic              same_v;
    logic [NODE_W-1:0] same_i;
    logic              oth_v;
    logic [NODE_W-1:0] oth_i;

    assign fill_out = fill_reg;
    assign tok_out  = tok_out_reg;

    // Read both the path node and the credited subtree root
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[tok_a_reg.node] <= wdata;
        end
        rd_a_reg  <= mem[tok_in.node];
        rd_c_reg  <= mem[tok_in.cred_node];
        fresh_reg <= ({1'b0, tok_in.node} >= fill_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_a_reg.valid   <= 1'b0;
            tok_out_reg.valid <= 1'b0;
            fill_reg          <= '0;
        end else begin
            tok_a_reg   <= tok_in;
            tok_out_reg <= tok_out_next;
            fill_reg    <= fill_next;
        end
    end

    // Walk one level: check, count or update the node on the path
    always_comb begin
        leaf   = (level == LVL_W'(KEY_BITS));
        pos    = KPOS_W'(KEY_BITS - 1 - int'(level));
        kb     = leaf ? 1'b0 : ctrl.key[pos];
        lb     = leaf ? 1'b0 : ctrl.limit[pos];
        ent    = fresh_reg ? '0 : rd_a_reg;
        same_v = kb ? ent.rv : ent.lv;
        same_i = kb ? ent.ri : ent.li;
        oth_v  = kb ? ent.lv : ent.rv;
        oth_i  = kb ? ent.li : ent.ri;

        tok_out_next         = tok_a_reg;
        tok_out_next.present = 1'b0;
        wdata                = ent;
        we                   = 1'b0;

        case (ctrl.mode)
            MODE_CHK_INS: begin
                if (level == '0) begin
                    tok_out_next.total = ent.cnt;
                end
                if (level != '0 && !tok_a_reg.present) begin
                    tok_out_next.missing = tok_a_reg.missing + LVL_W'(1);
                end
                if (tok_a_reg.present && !leaf) begin
                    tok_out_next.present = same_v;
                    tok_out_next.node    = same_i;
                end
            end
            MODE_CHK_REM: begin
                if (!tok_a_reg.present || ent.cnt == '0) begin
                    tok_out_next.bad = 1'b1;
                end
                if (tok_a_reg.present && !leaf) begin
                    tok_out_next.present = same_v;
                    tok_out_next.node    = same_i;
                end
            end
            MODE_QUERY: begin
                if (tok_a_reg.cred_v) begin
                    tok_out_next.total = tok_a_reg.total + rd_c_reg.cnt;
                end
                tok_out_next.cred_v = 1'b0;
                if (tok_a_reg.present && !leaf) begin
                    if (lb) begin
                        tok_out_next.cred_v    = same_v;
                        tok_out_next.cred_node = same_i;
                        tok_out_next.present   = oth_v;
                        tok_out_next.node      = oth_i;
                    end else begin
                        tok_out_next.present = same_v;
                        tok_out_next.node    = same_i;
                    end
                end
            end
            MODE_UPD_INS: begin
                we        = tok_a_reg.valid;
                wdata.cnt = ent.cnt + CNT_W'(1);
                tok_out_next.present = 1'b1;
                tok_out_next.node    = same_i;
                // Link a fresh node at the next level's fill point
                if (!leaf && !same_v) begin
                    tok_out_next.node = nxt_fill[NODE_W-1:0];
                    if (kb) begin
                        wdata.rv = 1'b1;
                        wdata.ri = nxt_fill[NODE_W-1:0];
                    end else begin
                        wdata.lv = 1'b1;
                        wdata.li = nxt_fill[NODE_W-1:0];
                    end
                end
            end
            MODE_UPD_REM: begin
                we        = tok_a_reg.valid;
                wdata.cnt = ent.cnt - CNT_W'(1);
                tok_out_next.present = 1'b1;
                tok_out_next.node    = same_i;
            end
            default: begin
                we = 1'b0;
            end
        endcase

        // Advance the fill count when a write lands at the fill point
        fill_next = fill_reg;
        if (we && {1'b0, tok_a_reg.node} == fill_reg) begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

endmodule

@@ hw/rtl/xor_trie_less_than_counter.sv @@
// Top level of the xor trie less-than counter: sequencer, result register
// and the row of level cells. Depends on xtlc_pkg and xtlc_cell.
`timescale 1ns / 1ps

//  channel | ports                    | word
//  input   | s_valid s_ready s_data   | opcode, key, limit
//  result  | m_valid m_ready m_data   | count, status
//
// A token walks the row of KEY_BITS+1 level cells; each cell has a node
// memory read stage, then an update stage.
// Query: one pass. Insert and remove: a check pass and, when the check
// passes, an update pass. Unknown opcode: no pass.
// Reset clears the fill counts; no memory sweep is needed.
// A finished result waits in the output register; the next word is taken
// while it waits.

module xor_trie_less_than_counter import xtlc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PASS1 = 2'd1;
    localparam logic [1:0] S_PASS2 = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]        state_reg, state_next;
    in_word_t          item_reg, item_next;
    logic [2:0]        mode_reg, mode_next;
    logic              launch_reg, launch_next;
    logic [FILL_W-1:0] nodes_reg, nodes_next;
    out_word_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    ctrl_t             ctrl;
    tok_t              tok [NCELLS+1];
    logic [FILL_W-1:0] fill [NCELLS+1];
    tok_t              done_tok;
    logic [FILL_W+1:0] need;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign ctrl.mode  = mode_reg;
    assign ctrl.key   = item_reg.key;
    assign ctrl.limit = item_reg.limit;

    // Launch token at the root
    always_comb begin
        tok[0]         = '0;
        tok[0].valid   = launch_reg;
        tok[0].present = 1'b1;
    end
    assign fill[NCELLS] = '0;
    assign done_tok     = tok[NCELLS];

    genvar g;
    generate
        for (g = 0; g < NCELLS; g++) begin : g_cell
            xtlc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .level    (LVL_W'(g)),
                .ctrl     (ctrl),
                .tok_in   (tok[g]),
                .nxt_fill (fill[g+1]),
                .fill_out (fill[g]),
                .tok_out  (tok[g+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            launch_reg  <= 1'b0;
            nodes_reg   <= FILL_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            nodes_reg   <= nodes_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg   <= item_next;
        mode_reg   <= mode_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // Sequence the check and update passes
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        mode_next    = mode_reg;
        launch_next  = 1'b0;
        nodes_next   = nodes_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        need         = {2'b00, nodes_reg} + (FILL_W+2)'(done_tok.missing);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    res_next  = '0;
                    case (s_data.opcode)
                        OP_INSERT: begin
                            mode_next   = MODE_CHK_INS;
                            launch_next = 1'b1;
                            state_next  = S_PASS1;
                        end
                        OP_REMOVE: begin
                            mode_next   = MODE_CHK_REM;
                            launch_next = 1'b1;
                            state_next  = S_PASS1;
                        end
                        OP_QUERY: begin
                            mode_next   = MODE_QUERY;
                            launch_next = 1'b1;
                            state_next  = S_PASS1;
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_PASS1: begin
                if (done_tok.valid) begin
                    state_next = S_FIN;
                    case (item_reg.opcode)
                        OP_INSERT: begin
                            if (need > (FILL_W+2)'(POOL_NODES)) begin
                                res_next.status = ST_POOL_FULL;
                            end else if (done_tok.total >= COUNT_MAX) begin
                                res_next.status = ST_OVERFLOW;
                            end else begin
                                nodes_next  = need[FILL_W-1:0];
                                mode_next   = MODE_UPD_INS;
                                launch_next = 1'b1;
                                state_next  = S_PASS2;
                            end
                        end
                        OP_REMOVE: begin
                            if (done_tok.bad) begin
                                res_next.status = ST_ABSENT;
                            end else begin
                                mode_next   = MODE_UPD_REM;
                                launch_next = 1'b1;
                                state_next  = S_PASS2;
                            end
                        end
                        default: begin
                            res_next.count = done_tok.total;
                        end
                    endcase
                end
            end
            S_PASS2: begin
                if (done_tok.valid) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ tb/xor_trie_less_than_counter_tb.sv @@
// Testbench for the xor trie less-than counter: directed table, then random
// insert/remove/query words checked against a behavioral trie.
// Depends on xtlc_pkg and the xor_trie_less_than_counter top level.
`timescale 1ns / 1ps

module xor_trie_less_than_counter_tb;
    import xtlc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 1700;
    localparam int TRIE_NODES     = 1 << 17;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    xor_trie_less_than_counter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Behavioral trie: links, counts and allocation pointer
    int unsigned trie_left [TRIE_NODES];
    int unsigned trie_right[TRIE_NODES];
    logic [15:0] trie_cnt  [TRIE_NODES];
    int unsigned trie_next;

    out_word_t expected_words[$];
    logic [30:0] stored_keys[$];
    int mismatches;
    int stall_cycles;
    bit run_done;
    bit stall_rx;

    function automatic int unsigned trie_child(int unsigned node, logic side);
        return side ? trie_right[node] : trie_left[node];
    endfunction

    function automatic logic [1:0] trie_insert(logic [30:0] key);
        int unsigned node;
        int unsigned nx;
        int unsigned missing;
        node = 0;
        missing = 0;
        for (int p = KEY_BITS - 1; p >= 0; p--) begin
            nx = trie_child(node, key[p]);
            if (nx == 0) begin
                missing = p + 1;
                break;
            end
            node = nx;
        end
        if (trie_next + missing > POOL_NODES) return ST_POOL_FULL;
        if (trie_cnt[0] == COUNT_MAX) return ST_OVERFLOW;
        node = 0;
        trie_cnt[0] = trie_cnt[0] + 16'd1;
        for (int p = KEY_BITS - 1; p >= 0; p--) begin
            nx = trie_child(node, key[p]);
            if (nx == 0) begin
                nx = trie_next;
                trie_next++;
                trie_left[nx] = 0;
                trie_right[nx] = 0;
                trie_cnt[nx] = 16'd0;
                if (key[p]) trie_right[node] = nx;
                else trie_left[node] = nx;
            end
            node = nx;
            trie_cnt[node] = trie_cnt[node] + 16'd1;
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] trie_remove(logic [30:0] key);
        int unsigned node;
        node = 0;
        if (trie_cnt[0] == 0) return ST_ABSENT;
        for (int p = KEY_BITS - 1; p >= 0; p--) begin
            node = trie_child(node, key[p]);
            if (node == 0 || trie_cnt[node] == 0) return ST_ABSENT;
        end
        node = 0;
        trie_cnt[0] = trie_cnt[0] - 16'd1;
        for (int p = KEY_BITS - 1; p >= 0; p--) begin
            node = trie_child(node, key[p]);
            trie_cnt[node] = trie_cnt[node] - 16'd1;
        end
        return ST_OK;
    endfunction

    function automatic logic [15:0] trie_count_below(logic [30:0] key, logic [30:0] lim);
        int unsigned node;
        int unsigned same;
        int unsigned total;
        node = 0;
        total = 0;
        for (int p = KEY_BITS - 1; p >= 0; p--) begin
            if (lim[p]) begin
                same = trie_child(node, key[p]);
                if (same != 0) total += trie_cnt[same];
                node = trie_child(node, !key[p]);
            end else begin
                node = trie_child(node, key[p]);
            end
            if (node == 0) break;
        end
        return total[15:0];
    endfunction

    function automatic out_word_t predict_word(in_word_t w);
        out_word_t r;
        r.count = 16'd0;
        r.status = ST_OK;
        case (w.opcode)
            OP_INSERT: r.status = trie_insert(w.key);
            OP_REMOVE: r.status = trie_remove(w.key);
            OP_QUERY:  r.count = trie_count_below(w.key, w.limit);
            default: ;
        endcase
        return r;
    endfunction

    // Predict without a net change: an update that succeeds is undone on the
    // live trie, which restores the counts; links made by an insert stay
    function automatic out_word_t predict_word_peek(in_word_t w);
        out_word_t r;
        if (w.opcode == OP_QUERY || w.opcode == OP_UNKNOWN) return predict_word(w);
        r = predict_word(w);
        if (r.status == ST_OK) begin
            if (w.opcode == OP_INSERT) void'(trie_remove(w.key));
            else void'(trie_insert(w.key));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Check each accepted result word against the oldest expectation
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", {14'd0, m_data}, 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (m_data.count !== want.count)
                    report_mismatch("count", {16'd0, m_data.count}, {16'd0, want.count});
                if (m_data.status !== want.status)
                    report_mismatch("status", {30'd0, m_data.status}, {30'd0, want.status});
            end
        end
    end

    // Random receiver stalls: mostly short, a few long, sometimes none
    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!stall_rx) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) m_ready <= 1'b1;
            else if (r < 97) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(0, 30) == 0);
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (!run_done) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL xor_trie_less_than_counter");
                $finish;
            end
        end
    end

    // Drive one word and hold it until accepted, then record its prediction;
    // drop valid only for a real gap so back-to-back words keep it high
    task automatic send_word(in_word_t w, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(predict_word(w));
    endtask

    // Drop valid and hold off until every expected word has come back
    task automatic drain_words();
        if (expected_words.size() != 0) begin
            s_valid <= 1'b0;
            while (expected_words.size() != 0) @(posedge aclk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [30:0] rand_key();
        logic [30:0] k;
        k = 31'($urandom());
        // Share upper bits often so that paths branch deep in the trie
        if ($urandom_range(0, 1)) k[30:6] = 25'h155_5555 ^ {24'd0, k[30]};
        return k;
    endfunction

    typedef struct {
        in_word_t  w;
        bit        has_want;
        out_word_t want;
    } stim_row_t;

    stim_row_t directed_rows[$];

    function automatic stim_row_t mk_row(logic [1:0] op, logic [30:0] k, logic [30:0] l,
                                         bit has_want, logic [15:0] c, logic [1:0] st);
        stim_row_t r;
        r.w.opcode = op;
        r.w.key = k;
        r.w.limit = l;
        r.has_want = has_want;
        r.want.count = c;
        r.want.status = st;
        return r;
    endfunction

    initial begin
        in_word_t w;
        out_word_t p;
        int r;
        int idx;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        mismatches = 0;
        run_done = 1'b0;
        stall_rx = 1'b0;
        for (int i = 0; i < TRIE_NODES; i++) begin
            trie_left[i] = 0;
            trie_right[i] = 0;
            trie_cnt[i] = 16'd0;
        end
        trie_next = 1;

        // Directed table: empty-trie cases, extremes, unknown opcode
        directed_rows.push_back(mk_row(OP_QUERY, '1, '1, 1, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_REMOVE, 31'd0, 31'd0, 1, 16'd0, ST_ABSENT));
        directed_rows.push_back(mk_row(OP_UNKNOWN, '1, '1, 1, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_INSERT, 31'd0, '1, 1, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_INSERT, '1, 31'd0, 1, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_INSERT, '1, 31'h5555_5555, 1, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_QUERY, 31'd0, '1, 1, 16'd1, ST_OK));
        directed_rows.push_back(mk_row(OP_QUERY, 31'd0, 31'd0, 1, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_QUERY, 31'd0, 31'd1, 1, 16'd1, ST_OK));
        directed_rows.push_back(mk_row(OP_QUERY, '1, 31'd1, 1, 16'd2, ST_OK));
        directed_rows.push_back(mk_row(OP_QUERY, 31'h2AAA_AAAA, 31'h4000_0000, 0, 16'd0,
                                       ST_OK));
        directed_rows.push_back(mk_row(OP_REMOVE, 31'd1, 31'd0, 1, 16'd0, ST_ABSENT));
        directed_rows.push_back(mk_row(OP_REMOVE, '1, '1, 1, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_REMOVE, '1, 31'd0, 1, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_REMOVE, '1, 31'd0, 1, 16'd0, ST_ABSENT));
        directed_rows.push_back(mk_row(OP_QUERY, 31'h7FFF_FFFE, '1, 0, 16'd0, ST_OK));
        directed_rows.push_back(mk_row(OP_UNKNOWN, 31'h1234_5678, 31'd0, 1, 16'd0, ST_OK));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            w = directed_rows[i].w;
            if (directed_rows[i].has_want) begin
                p = predict_word_peek(w);
                if (p !== directed_rows[i].want)
                    report_mismatch("table row", {14'd0, p}, {14'd0, directed_rows[i].want});
            end
            send_word(w, pick_gap());
            if (w.opcode == OP_INSERT) stored_keys.push_back(w.key);
        end
        stall_rx = 1'b1;

        // Hold off until every result is in, at least once
        drain_words();

        // Random part: inserts of fresh or repeated keys, removes of stored
        // keys, queries near stored keys, with noise and unknown opcodes
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            r = $urandom_range(0, 99);
            w.limit = 31'($urandom());
            if ($urandom_range(0, 3) == 0) w.limit = 31'($urandom_range(0, 63));
            if (r < 35) begin
                w.opcode = OP_INSERT;
                if (stored_keys.size() != 0 && $urandom_range(0, 3) == 0)
                    w.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                else
                    w.key = rand_key();
                stored_keys.push_back(w.key);
            end else if (r < 55) begin
                w.opcode = OP_REMOVE;
                if (stored_keys.size() != 0 && $urandom_range(0, 4) != 0) begin
                    idx = $urandom_range(0, stored_keys.size() - 1);
                    w.key = stored_keys[idx];
                    stored_keys.delete(idx);
                end else begin
                    w.key = rand_key();
                end
            end else if (r < 97) begin
                w.opcode = OP_QUERY;
                if (stored_keys.size() != 0 && $urandom_range(0, 1))
                    w.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
                            ^ 31'($urandom_range(0, 255));
                else
                    w.key = rand_key();
            end else begin
                w.opcode = OP_UNKNOWN;
                w.key = 31'($urandom());
            end
            send_word(w, pick_gap());
            if (n == RANDOM_WORDS / 2)
                drain_words();
        end

        drain_words();
        repeat (200) @(posedge aclk);
        run_done = 1'b1;
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS xor_trie_less_than_counter");
        end else begin
            $display("FAIL xor_trie_less_than_counter");
        end
        $finish;
    end

endmodule
